/* sv/npr_pkg.sv */
// Shared types and constants for the next-prime search block.
// No dependencies; used by npr_rem and next_prime_search.
package npr_pkg;

    localparam int unsigned TWO       = 2;
    localparam int unsigned THREE     = 3;
    localparam int unsigned FIRST_DIV = 5;
    localparam int unsigned DIV_STEP  = 6;
    localparam int unsigned FIRST_SQ  = FIRST_DIV * FIRST_DIV;
    // (d+6)^2 - d^2 = 12*d + 36
    localparam int unsigned SQ_STEP   = DIV_STEP * DIV_STEP;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_stat_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CAND  = 7'b0000010,
        S_DIV3  = 7'b0000100,
        S_TEST  = 7'b0001000,
        S_DIVA  = 7'b0010000,
        S_DIVB  = 7'b0100000,
        S_FOUND = 7'b1000000
    } state_t;

endpackage

/* sv/next_prime_search.sv */
// Next prime strictly above a start value, by trial division.
// Sequencer over the shared remainder unit npr_rem; depends on npr_pkg.
//
// channel  dir  fields (low bit up)          accepted when
// s_*      in   tdata: start_value            s_tvalid & s_tready
// m_*      out  tdata: next_prime_value       m_tvalid & m_tready
//
// Each trial division is one pass through the remainder unit; a candidate is divided
// by 3, then by d and d+2 for d = 5 upward in steps of 6 while d*d does not exceed
// it, until a prime is found. Start values 0 and 1 give 2 without a search.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next request is taken while it waits.
// Reset clears the sequencer and the output valid flag.
module next_prime_search #(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,  // start_value
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((VALUE_BITS+8)/8)*8-1:0]       m_tdata   // next_prime_value
);
    import npr_pkg::*;

    localparam int unsigned CW     = VALUE_BITS + 1;
    localparam int unsigned SW     = 2 * CW;
    localparam int unsigned OUT_W  = ((VALUE_BITS + 8) / 8) * 8;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cand_reg, cand_next;
    logic [CW-1:0]   d_reg, d_next;
    logic [SW-1:0]   sq_reg, sq_next;
    logic [CW-1:0]   out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic            rem_start;
    logic [CW-1:0]   rem_div;
    rem_stat_t       rem_stat;
    logic [VALUE_BITS-1:0] start_val;
    logic [SW-1:0]   d_wide;

    assign start_val = s_tdata[VALUE_BITS-1:0];
    assign d_wide    = SW'(d_reg);

    npr_rem #(
        .W (CW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (cand_reg),
        .divisor  (rem_div),
        .stat     (rem_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rem_start      = 1'b0;
        rem_div        = d_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (start_val <= VALUE_BITS'(1))
                    begin
                        cand_next  = CW'(TWO);
                        state_next = S_FOUND;
                    end
                    else
                    begin
                        cand_next  = {1'b0, start_val} + CW'(1);
                        state_next = S_CAND;
                    end
                end
            end
            S_CAND:
            begin
                if (cand_reg <= CW'(THREE))
                    state_next = S_FOUND;
                else if (!cand_reg[0])
                    cand_next = cand_reg + CW'(1);
                else
                begin
                    rem_div    = CW'(THREE);
                    rem_start  = 1'b1;
                    state_next = S_DIV3;
                end
            end
            S_DIV3:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        cand_next  = cand_reg + CW'(1);
                        state_next = S_CAND;
                    end
                    else
                    begin
                        d_next     = CW'(FIRST_DIV);
                        sq_next    = SW'(FIRST_SQ);
                        state_next = S_TEST;
                    end
                end
            end
            S_TEST:
            begin
                if (sq_reg > SW'(cand_reg))
                    state_next = S_FOUND;
                else
                begin
                    rem_start  = 1'b1;
                    state_next = S_DIVA;
                end
            end
            S_DIVA:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        cand_next  = cand_reg + CW'(1);
                        state_next = S_CAND;
                    end
                    else
                    begin
                        rem_div    = d_reg + CW'(TWO);
                        rem_start  = 1'b1;
                        state_next = S_DIVB;
                    end
                end
            end
            S_DIVB:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        cand_next  = cand_reg + CW'(1);
                        state_next = S_CAND;
                    end
                    else
                    begin
                        d_next     = d_reg + CW'(DIV_STEP);
                        sq_next    = sq_reg + (d_wide << 3) + (d_wide << 2) + SW'(SQ_STEP);
                        state_next = S_TEST;
                    end
                end
            end
            S_FOUND:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = cand_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        d_reg    <= d_next;
        sq_reg   <= sq_next;
        out_reg  <= out_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_reg);

`ifndef SYNTHESIS
    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rem_stat.busy)
        else $error("remainder unit busy while idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rem_stat.done |-> (state_reg == S_DIV3 || state_reg == S_DIVA || state_reg == S_DIVB))
        else $error("remainder result outside a wait state");

    a_result_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg >= CW'(TWO)))
        else $error("result below two");
`endif

endmodule

/* sv/npr_rem.sv */
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on npr_pkg (rem_stat_t).
module npr_rem #(
    parameter int unsigned W = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    output npr_pkg::rem_stat_t stat
);
    import npr_pkg::*;

    localparam int unsigned CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     shift_reg, shift_next;
    logic [W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial = {rem_reg, shift_reg[W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = '0;
            shift_next = dividend;
            div_next   = divisor;
            cnt_next   = CNT_W'(W);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = diff[W-1:0];
            else
                rem_next = trial[W-1:0];
            shift_next = {shift_reg[W-2:0], 1'b0};
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        div_reg   <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule
